// File: src/ftpp_pkg.sv
package ftpp_pkg;

    localparam int unsigned SEQ_MODULUS = 255;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_CODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_TAG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_TAG   = 3'd4;

    localparam logic [7:0] RST_DATA_CODE  = 8'd1;
    localparam logic [7:0] RST_START_CODE = 8'd2;
    localparam logic [7:0] RST_END_CODE   = 8'd3;
    localparam logic [7:0] RST_SIZE_TAG   = 8'd0;
    localparam logic [7:0] RST_NAME_TAG   = 8'd1;

    typedef logic [2:0] t_event;
    localparam t_event EV_NONE     = 3'd0;
    localparam t_event EV_PAYLOAD  = 3'd1;
    localparam t_event EV_NAME     = 3'd2;
    localparam t_event EV_START_OK = 3'd3;
    localparam t_event EV_DATA_OK  = 3'd4;
    localparam t_event EV_END_OK   = 3'd5;

    typedef logic [2:0] t_error;
    localparam t_error ERR_NONE      = 3'd0;
    localparam t_error ERR_BAD_CODE  = 3'd1;
    localparam t_error ERR_BAD_SEQ   = 3'd2;
    localparam t_error ERR_SHORT     = 3'd3;
    localparam t_error ERR_LEN       = 3'd4;
    localparam t_error ERR_FIELD_CUT = 3'd5;
    localparam t_error ERR_NO_NAME   = 3'd6;
    localparam t_error ERR_SIZE_DIFF = 3'd7;

    typedef logic [1:0] t_class;
    localparam t_class CLS_NONE  = 2'd0;
    localparam t_class CLS_START = 2'd1;
    localparam t_class CLS_DATA  = 2'd2;
    localparam t_class CLS_END   = 2'd3;

    typedef logic [2:0] t_pos;
    localparam t_pos POS_FIRST   = 3'd0;
    localparam t_pos POS_SEQ     = 3'd1;
    localparam t_pos POS_LEN_HI  = 3'd2;
    localparam t_pos POS_LEN_LO  = 3'd3;
    localparam t_pos POS_PAYLOAD = 3'd4;
    localparam t_pos POS_TAG     = 3'd1;
    localparam t_pos POS_LEN     = 3'd2;
    localparam t_pos POS_VAL     = 3'd3;

endpackage

// File: src/ftpp_in_if.sv
interface ftpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

// File: src/ftpp_out_if.sv
interface ftpp_out_if #(
    parameter int SIZE_BITS = 64
);
    logic                 valid;
    logic                 ready;
    logic [2:0]           event_res;
    logic [7:0]           byte_out;
    logic [2:0]           error;
    logic [SIZE_BITS-1:0] size_out;

    modport source (output valid, output event_res, output byte_out, output error,
                    output size_out, input ready);
    modport sink (input valid, input event_res, input byte_out, input error,
                  input size_out, output ready);
endinterface

// File: src/file_transfer_packet_parser_core.sv
// path: an accepted byte passes the input register, then the result register, to its result item
// throughput: one byte per cycle while result items are taken, limited by the state update of the parser
// the input stalls only while both registers hold items and the result item is not taken
// reset: synchronous, active low; clears all parser state, empties both registers
// and restores the control code and field tag registers to their defaults
module file_transfer_packet_parser_core #(
    parameter int SIZE_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ftpp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [7:0]                      i_cfg_wdata,
    ftpp_in_if.sink                         i_in,
    ftpp_out_if.source                      o_out
);

    logic [7:0] r_data_code, r_start_code, r_end_code, r_size_tag, r_name_tag;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic                 r_out_valid;
    ftpp_pkg::t_event     r_out_event;
    logic [7:0]           r_out_byte;
    ftpp_pkg::t_error     r_out_error;
    logic [SIZE_BITS-1:0] r_out_size;

    logic                 r_phase, n_phase;
    ftpp_pkg::t_pos       r_pos, n_pos;
    ftpp_pkg::t_class     r_cls, n_cls;
    logic                 r_skip, n_skip;
    logic [7:0]           r_seq, n_seq;
    logic [15:0]          r_decl, n_decl;
    logic [16:0]          r_seen, n_seen;
    logic [7:0]           r_tag, n_tag;
    logic [7:0]           r_rem, n_rem;
    logic [SIZE_BITS-1:0] r_acc, n_acc;
    logic [SIZE_BITS-1:0] r_start_size, n_start_size;
    logic                 r_name_seen, n_name_seen;

    ftpp_pkg::t_event     c_event;
    logic [7:0]           c_byte;
    ftpp_pkg::t_error     c_error;
    logic [SIZE_BITS-1:0] c_size;
    logic                 c_done;
    logic [8:0]           c_seq_inc;

    logic advance;
    logic in_take;

    assign advance     = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_in_valid || advance;
    assign in_take     = i_in.valid && i_in.ready;

    assign o_out.valid     = r_out_valid;
    assign o_out.event_res = r_out_event;
    assign o_out.byte_out  = r_out_byte;
    assign o_out.error     = r_out_error;
    assign o_out.size_out  = r_out_size;

    assign c_seq_inc = {1'b0, r_seq} + 9'd1;

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_cls        = r_cls;
        n_skip       = r_skip;
        n_seq        = r_seq;
        n_decl       = r_decl;
        n_seen       = r_seen;
        n_tag        = r_tag;
        n_rem        = r_rem;
        n_acc        = r_acc;
        n_start_size = r_start_size;
        n_name_seen  = r_name_seen;
        c_event      = ftpp_pkg::EV_NONE;
        c_byte       = 8'd0;
        c_error      = ftpp_pkg::ERR_NONE;
        c_size       = '0;
        c_done       = 1'b0;

        if (r_skip) begin
            if (r_in_last) begin
                n_skip = 1'b0;
                n_pos  = ftpp_pkg::POS_FIRST;
                n_cls  = ftpp_pkg::CLS_NONE;
            end
        end else if (r_pos == ftpp_pkg::POS_FIRST) begin
            if (!r_phase && r_in_byte == r_start_code) begin
                n_cls = ftpp_pkg::CLS_START;
            end else if (r_phase && r_in_byte == r_end_code) begin
                n_cls = ftpp_pkg::CLS_END;
            end else if (r_phase && r_in_byte == r_data_code) begin
                n_cls = ftpp_pkg::CLS_DATA;
            end else begin
                c_error = ftpp_pkg::ERR_BAD_CODE;
            end
            if (c_error == ftpp_pkg::ERR_NONE) begin
                n_pos = ftpp_pkg::POS_SEQ;
                if (n_cls == ftpp_pkg::CLS_DATA) begin
                    n_decl = 16'd0;
                    n_seen = 17'd0;
                    if (r_in_last) begin
                        c_error = ftpp_pkg::ERR_SHORT;
                    end
                end else begin
                    n_acc       = '0;
                    n_name_seen = 1'b0;
                    n_rem       = 8'd0;
                    if (r_in_last) begin
                        c_error = ftpp_pkg::ERR_NO_NAME;
                    end
                end
            end
        end else if (r_cls == ftpp_pkg::CLS_DATA) begin
            case (r_pos)
                ftpp_pkg::POS_SEQ: begin
                    if (r_in_last) begin
                        c_error = ftpp_pkg::ERR_SHORT;
                    end else if (r_in_byte != r_seq) begin
                        c_error = ftpp_pkg::ERR_BAD_SEQ;
                    end else begin
                        n_pos = ftpp_pkg::POS_LEN_HI;
                    end
                end
                ftpp_pkg::POS_LEN_HI: begin
                    if (r_in_last) begin
                        c_error = ftpp_pkg::ERR_SHORT;
                    end else begin
                        n_decl = {r_in_byte, 8'd0};
                        n_pos  = ftpp_pkg::POS_LEN_LO;
                    end
                end
                ftpp_pkg::POS_LEN_LO: begin
                    n_decl = {r_decl[15:8], r_in_byte};
                    n_pos  = ftpp_pkg::POS_PAYLOAD;
                    if (r_in_last) begin
                        if (n_decl == 16'd0) begin
                            c_event = ftpp_pkg::EV_DATA_OK;
                        end else begin
                            c_error = ftpp_pkg::ERR_LEN;
                        end
                    end
                end
                default: begin
                    n_seen = r_seen + 17'd1;
                    if (n_seen > {1'b0, r_decl}) begin
                        c_error = ftpp_pkg::ERR_LEN;
                    end else if (r_in_last) begin
                        if (n_seen == {1'b0, r_decl}) begin
                            c_event = ftpp_pkg::EV_DATA_OK;
                            c_byte  = r_in_byte;
                        end else begin
                            c_error = ftpp_pkg::ERR_LEN;
                        end
                    end else begin
                        c_event = ftpp_pkg::EV_PAYLOAD;
                        c_byte  = r_in_byte;
                    end
                end
            endcase
            if (c_event == ftpp_pkg::EV_DATA_OK) begin
                n_seq = (c_seq_inc == 9'(ftpp_pkg::SEQ_MODULUS)) ? 8'd0 : c_seq_inc[7:0];
                n_pos = ftpp_pkg::POS_FIRST;
                n_cls = ftpp_pkg::CLS_NONE;
            end
        end else begin
            case (r_pos)
                ftpp_pkg::POS_TAG: begin
                    n_tag = r_in_byte;
                    n_pos = ftpp_pkg::POS_LEN;
                    if (r_in_last) begin
                        c_error = ftpp_pkg::ERR_FIELD_CUT;
                    end
                end
                ftpp_pkg::POS_LEN: begin
                    n_rem = r_in_byte;
                    if (r_tag != r_size_tag && r_tag == r_name_tag) begin
                        n_name_seen = 1'b1;
                    end
                    n_pos  = (r_in_byte == 8'd0) ? ftpp_pkg::POS_TAG : ftpp_pkg::POS_VAL;
                    c_done = r_in_last && r_in_byte == 8'd0;
                    if (r_in_last && r_in_byte != 8'd0) begin
                        c_error = ftpp_pkg::ERR_FIELD_CUT;
                    end
                end
                default: begin
                    if (r_tag == r_size_tag) begin
                        n_acc = SIZE_BITS'({r_acc, r_in_byte});
                    end else if (r_tag == r_name_tag) begin
                        c_event = ftpp_pkg::EV_NAME;
                        c_byte  = r_in_byte;
                    end
                    n_rem = r_rem - 8'd1;
                    if (n_rem == 8'd0) begin
                        n_pos = ftpp_pkg::POS_TAG;
                    end
                    if (r_in_last) begin
                        if (n_rem == 8'd0) begin
                            c_done = 1'b1;
                        end else begin
                            c_error = ftpp_pkg::ERR_FIELD_CUT;
                        end
                    end
                end
            endcase
            if (c_done) begin
                c_event = ftpp_pkg::EV_NONE;
                n_pos   = ftpp_pkg::POS_FIRST;
                n_cls   = ftpp_pkg::CLS_NONE;
                if (!n_name_seen) begin
                    c_error = ftpp_pkg::ERR_NO_NAME;
                end else if (r_cls == ftpp_pkg::CLS_START) begin
                    n_start_size = n_acc;
                    n_phase      = 1'b1;
                    n_seq        = 8'd0;
                    c_event      = ftpp_pkg::EV_START_OK;
                    c_size       = n_acc;
                end else begin
                    n_phase = 1'b0;
                    if (n_acc != r_start_size) begin
                        c_error = ftpp_pkg::ERR_SIZE_DIFF;
                    end else begin
                        c_event = ftpp_pkg::EV_END_OK;
                        c_size  = n_acc;
                    end
                end
            end
        end

        if (c_error != ftpp_pkg::ERR_NONE) begin
            c_event = ftpp_pkg::EV_NONE;
            c_byte  = 8'd0;
            c_size  = '0;
            n_phase = 1'b0;
            n_pos   = ftpp_pkg::POS_FIRST;
            n_cls   = ftpp_pkg::CLS_NONE;
            n_skip  = !r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_code  <= ftpp_pkg::RST_DATA_CODE;
            r_start_code <= ftpp_pkg::RST_START_CODE;
            r_end_code   <= ftpp_pkg::RST_END_CODE;
            r_size_tag   <= ftpp_pkg::RST_SIZE_TAG;
            r_name_tag   <= ftpp_pkg::RST_NAME_TAG;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ftpp_pkg::CFG_DATA_CODE:  r_data_code  <= i_cfg_wdata;
                ftpp_pkg::CFG_START_CODE: r_start_code <= i_cfg_wdata;
                ftpp_pkg::CFG_END_CODE:   r_end_code   <= i_cfg_wdata;
                ftpp_pkg::CFG_SIZE_TAG:   r_size_tag   <= i_cfg_wdata;
                ftpp_pkg::CFG_NAME_TAG:   r_name_tag   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_byte <= i_in.byte_in;
            r_in_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (advance && r_in_valid) begin
            r_out_event <= c_event;
            r_out_byte  <= c_byte;
            r_out_error <= c_error;
            r_out_size  <= c_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= 1'b0;
            r_pos        <= ftpp_pkg::POS_FIRST;
            r_cls        <= ftpp_pkg::CLS_NONE;
            r_skip       <= 1'b0;
            r_seq        <= 8'd0;
            r_decl       <= 16'd0;
            r_seen       <= 17'd0;
            r_tag        <= 8'd0;
            r_rem        <= 8'd0;
            r_acc        <= '0;
            r_start_size <= '0;
            r_name_seen  <= 1'b0;
        end else if (advance && r_in_valid) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_cls        <= n_cls;
            r_skip       <= n_skip;
            r_seq        <= n_seq;
            r_decl       <= n_decl;
            r_seen       <= n_seen;
            r_tag        <= n_tag;
            r_rem        <= n_rem;
            r_acc        <= n_acc;
            r_start_size <= n_start_size;
            r_name_seen  <= n_name_seen;
        end
    end

endmodule

// File: src/ftpp_checker.sv
module ftpp_checker #(
    parameter int SIZE_BITS = 64
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [2:0]           i_out_event,
    input logic [7:0]           i_out_byte,
    input logic [2:0]           i_out_error,
    input logic [SIZE_BITS-1:0] i_out_size
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_event)
            && $stable(i_out_byte) && $stable(i_out_error) && $stable(i_out_size))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error != ftpp_pkg::ERR_NONE |->
            i_out_event == ftpp_pkg::EV_NONE && i_out_byte == 8'd0 && i_out_size == '0)
        else $error("error item carries an event or data");

    a_size_only_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_event != ftpp_pkg::EV_START_OK
            && i_out_event != ftpp_pkg::EV_END_OK |-> i_out_size == '0)
        else $error("file size outside a control frame result");

endmodule

bind file_transfer_packet_parser_core ftpp_checker #(.SIZE_BITS(SIZE_BITS)) u_ftpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_event (o_out.event_res),
    .i_out_byte  (o_out.byte_out),
    .i_out_error (o_out.error),
    .i_out_size  (o_out.size_out)
);
